FILE: hdl/cbmr_pkg.sv
// shared types, codes and helpers for the cartridge bank mapper with rtc
package cbmr_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_ROM    = 3'd1,
    KIND_RAM_RD = 3'd2,
    KIND_RAM_WR = 3'd3,
    KIND_NONE   = 3'd4
  } kind_e;

  typedef enum logic [0:0] {
    CFG_ROM_BANK_COUNT = 1'b0,
    CFG_RAM_BANK_COUNT = 1'b1
  } cfg_idx_e;

  localparam logic [3:0] SEL_RTC_SEC    = 4'h8;
  localparam logic [3:0] SEL_RTC_MIN    = 4'h9;
  localparam logic [3:0] SEL_RTC_HOUR   = 4'hA;
  localparam logic [3:0] SEL_RTC_DAY_LO = 4'hB;
  localparam logic [3:0] SEL_RTC_DAY_HI = 4'hC;
  localparam logic [3:0] SEL_RAM_LAST   = 4'h3;

  localparam logic [3:0] ENABLE_KEY     = 4'hA;
  localparam logic [7:0] OPEN_BUS       = 8'hFF;

  localparam logic [7:0] ROM_COUNT_RST  = 8'd2;
  localparam logic [2:0] RAM_COUNT_RST  = 3'd0;

  typedef struct packed {
    kind_e       kind;
    logic [20:0] mem_address;
    logic [7:0]  read_data;
    logic [7:0]  ram_write_data;
  } res_t;

  function automatic logic [5:0] mod60(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd240) r = r - 8'd240;
    if (r >= 8'd120) r = r - 8'd120;
    if (r >= 8'd60)  r = r - 8'd60;
    return r[5:0];
  endfunction

  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd192) r = r - 8'd192;
    if (r >= 8'd96)  r = r - 8'd96;
    if (r >= 8'd48)  r = r - 8'd48;
    if (r >= 8'd24)  r = r - 8'd24;
    return r[4:0];
  endfunction

endpackage

FILE: hdl/cartridge_bank_mapper_rtc_top.sv
// top level of the cartridge bank mapper with real-time clock
// Each input beat (bus read, bus write or one-second tick) is decoded against the current
// mapper and clock state and its one result beat is registered on accept, so the block
// takes one beat per clock; the only hold-off is a full output register whose beat the
// sink stalls. ROM and RAM accesses come out as physical addresses for external memory,
// rtc and open-bus reads carry their byte in read_data_o. The config port is always
// ready; the user must write it only while the block is idle, which goes unchecked.
module cartridge_bank_mapper_rtc_top
  import cbmr_pkg::*;
#(
  parameter int ROM_BANK_BITS = 7,
  parameter int RAM_BANK_BITS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [20:0] mem_address_o,
  output logic [7:0]  read_data_o,
  output logic [7:0]  ram_write_data_o
);

  localparam logic [6:0] RomWidthMask = 7'((1 << ROM_BANK_BITS) - 1);
  localparam logic [1:0] RamWidthMask = 2'((1 << RAM_BANK_BITS) - 1);

  logic [7:0]  rom_cnt_q;
  logic [2:0]  ram_cnt_q;
  logic [6:0]  rom_bank_q, rom_bank_d;
  logic [3:0]  sel_q, sel_d;
  logic        enable_q, enable_d;
  logic        latch_arm_q, latch_arm_d;
  logic        latched_q, latched_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [8:0]  day_q, day_d;
  logic        halt_q, halt_d;
  logic        carry_q, carry_d;
  logic [27:0] lat_time_q, lat_time_d;
  logic [1:0]  lat_flags_q, lat_flags_d;

  logic        out_valid_q;
  res_t        res_q, res_d;

  logic        accept;
  logic        ext;
  logic        is_ram;
  logic        is_rtc;
  logic [6:0]  rom_mask;
  logic [1:0]  ram_mask;
  logic [20:0] ram_addr;
  logic [7:0]  rtc_byte;
  logic [5:0]  rd_sec, rd_min;
  logic [4:0]  rd_hour;
  logic [8:0]  rd_day;
  logic        rd_halt, rd_carry;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_cnt_q <= ROM_COUNT_RST;
      ram_cnt_q <= RAM_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROM_BANK_COUNT: rom_cnt_q <= cfg_data_i;
        CFG_RAM_BANK_COUNT: ram_cnt_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // address mapping
  always_comb begin
    rom_mask = (rom_cnt_q == 8'd0) ? 7'd0 : 7'(rom_cnt_q - 8'd1);
    rom_mask = rom_mask & RomWidthMask;
    ram_mask = (ram_cnt_q == 3'd0) ? 2'd0 : 2'(ram_cnt_q - 3'd1);
    ram_mask = ram_mask & RamWidthMask;
    ram_addr = {6'd0, sel_q[1:0] & ram_mask, address_i[12:0]};
    ext      = (address_i[15:13] == 3'b101) && enable_q;
    is_ram   = (sel_q <= SEL_RAM_LAST) && (ram_cnt_q != 3'd0);
    is_rtc   = (sel_q >= SEL_RTC_SEC) && (sel_q <= SEL_RTC_DAY_HI);
  end

  // rtc read: latched copy once any latch happened
  always_comb begin
    if (latched_q) begin
      rd_sec   = lat_time_q[5:0];
      rd_min   = lat_time_q[11:6];
      rd_hour  = lat_time_q[16:12];
      rd_day   = lat_time_q[25:17];
      rd_halt  = lat_flags_q[0];
      rd_carry = lat_flags_q[1];
    end else begin
      rd_sec   = sec_q;
      rd_min   = min_q;
      rd_hour  = hour_q;
      rd_day   = day_q;
      rd_halt  = halt_q;
      rd_carry = carry_q;
    end
    case (sel_q)
      SEL_RTC_SEC:    rtc_byte = {2'd0, rd_sec};
      SEL_RTC_MIN:    rtc_byte = {2'd0, rd_min};
      SEL_RTC_HOUR:   rtc_byte = {3'd0, rd_hour};
      SEL_RTC_DAY_LO: rtc_byte = rd_day[7:0];
      SEL_RTC_DAY_HI: rtc_byte = {rd_carry, rd_halt, 5'd0, rd_day[8]};
      default:        rtc_byte = OPEN_BUS;
    endcase
  end

  // per-beat state update and result
  always_comb begin
    rom_bank_d  = rom_bank_q;
    sel_d       = sel_q;
    enable_d    = enable_q;
    latch_arm_d = latch_arm_q;
    latched_d   = latched_q;
    sec_d       = sec_q;
    min_d       = min_q;
    hour_d      = hour_q;
    day_d       = day_q;
    halt_d      = halt_q;
    carry_d     = carry_q;
    lat_time_d  = lat_time_q;
    lat_flags_d = lat_flags_q;
    res_d       = '{kind: KIND_NONE, mem_address: '0, read_data: '0, ram_write_data: '0};

    case (req_e'(req_type_i))
      REQ_READ: begin
        if (address_i[15:14] == 2'b00) begin
          res_d.kind        = KIND_ROM;
          res_d.mem_address = 21'(address_i);
        end else if (address_i[15:14] == 2'b01) begin
          res_d.kind        = KIND_ROM;
          res_d.mem_address = {rom_bank_q & rom_mask, address_i[13:0]};
        end else if (ext && is_ram) begin
          res_d.kind        = KIND_RAM_RD;
          res_d.mem_address = ram_addr;
        end else begin
          res_d.kind      = KIND_DATA;
          res_d.read_data = (ext && is_rtc) ? rtc_byte : OPEN_BUS;
        end
      end
      REQ_WRITE: begin
        case (address_i[15:13])
          3'b000: enable_d = (write_data_i[3:0] == ENABLE_KEY);
          3'b001: rom_bank_d = (write_data_i[6:0] == 7'd0) ? 7'd1 : write_data_i[6:0];
          3'b010: sel_d = write_data_i[3:0];
          3'b011: begin
            if (!latch_arm_q && write_data_i[0]) begin
              lat_time_d  = {2'd0, day_q, hour_q, min_q, sec_q};
              lat_flags_d = {carry_q, halt_q};
              latched_d   = 1'b1;
            end
            latch_arm_d = write_data_i[0];
          end
          default: begin
            if (ext && is_ram) begin
              res_d.kind           = KIND_RAM_WR;
              res_d.mem_address    = ram_addr;
              res_d.ram_write_data = write_data_i;
            end else if (ext && is_rtc) begin
              case (sel_q)
                SEL_RTC_SEC:    sec_d = mod60(write_data_i);
                SEL_RTC_MIN:    min_d = mod60(write_data_i);
                SEL_RTC_HOUR:   hour_d = mod24(write_data_i);
                SEL_RTC_DAY_LO: day_d = {day_q[8], write_data_i};
                SEL_RTC_DAY_HI: begin
                  day_d   = {write_data_i[0], day_q[7:0]};
                  halt_d  = write_data_i[6];
                  carry_d = write_data_i[7];
                end
                default: ;
              endcase
            end
          end
        endcase
      end
      REQ_TICK: begin
        if (!halt_q) begin
          if (sec_q < 6'd59) begin
            sec_d = sec_q + 6'd1;
          end else begin
            sec_d = '0;
            if (min_q < 6'd59) begin
              min_d = min_q + 6'd1;
            end else begin
              min_d = '0;
              if (hour_q < 5'd23) begin
                hour_d = hour_q + 5'd1;
              end else begin
                hour_d = '0;
                day_d  = day_q + 9'd1;
                if (day_q == 9'd511) carry_d = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q  <= 7'd1;
      sel_q       <= '0;
      enable_q    <= 1'b0;
      latch_arm_q <= 1'b0;
      latched_q   <= 1'b0;
      sec_q       <= '0;
      min_q       <= '0;
      hour_q      <= '0;
      day_q       <= '0;
      halt_q      <= 1'b0;
      carry_q     <= 1'b0;
      lat_time_q  <= '0;
      lat_flags_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rom_bank_q  <= rom_bank_d;
        sel_q       <= sel_d;
        enable_q    <= enable_d;
        latch_arm_q <= latch_arm_d;
        latched_q   <= latched_d;
        sec_q       <= sec_d;
        min_q       <= min_d;
        hour_q      <= hour_d;
        day_q       <= day_d;
        halt_q      <= halt_d;
        carry_q     <= carry_d;
        lat_time_q  <= lat_time_d;
        lat_flags_q <= lat_flags_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = res_q.kind;
  assign mem_address_o    = res_q.mem_address;
  assign read_data_o      = res_q.read_data;
  assign ram_write_data_o = res_q.ram_write_data;

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q < 6'd60 && min_q < 6'd60 && hour_q < 5'd24)
    else $error("rtc time field out of range");

  a_rom_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rom_bank_q != 7'd0)
    else $error("rom bank register holds zero");

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no result");

  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(latched_q))
    else $error("latch flag cleared");

endmodule

FILE: sim/cbmr_checker.sv
// checker for the cartridge bank mapper: tracks mapper and clock state, predicts and compares beats
`timescale 1ns / 100ps

module cbmr_checker
  import cbmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  result_kind_i,
  input  logic [20:0] mem_address_i,
  input  logic [7:0]  read_data_i,
  input  logic [7:0]  ram_write_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int ROM_BITS = 7;
  localparam int RAM_BITS = 2;

  logic [7:0]  rom_count;
  logic [2:0]  ram_count;
  logic [6:0]  rom_sel_bank;
  logic [3:0]  sel;
  logic        ext_en;
  logic        arm;
  logic        has_latch;
  logic [5:0]  sec;
  logic [5:0]  mins;
  logic [4:0]  hrs;
  logic [8:0]  days;
  logic        halted;
  logic        carry;
  logic [27:0] snap_time;
  logic [1:0]  snap_flags;

  res_t bus_results_q[$];
  res_t want;
  res_t mapped;

  function automatic logic [7:0] count_mask(input logic [7:0] count, input int bits);
    logic [7:0] m;
    m = (count == 8'd0) ? 8'd0 : count - 8'd1;
    return m & 8'((1 << bits) - 1);
  endfunction

  function automatic logic [7:0] clock_byte(input logic [3:0] s);
    logic [5:0] b_sec;
    logic [5:0] b_min;
    logic [4:0] b_hr;
    logic [8:0] b_day;
    logic       b_halt;
    logic       b_carry;
    {b_day, b_hr, b_min, b_sec} = has_latch ? snap_time[25:0] : {days, hrs, mins, sec};
    {b_carry, b_halt} = has_latch ? snap_flags : {carry, halted};
    case (s)
      SEL_RTC_SEC:    return {2'b00, b_sec};
      SEL_RTC_MIN:    return {2'b00, b_min};
      SEL_RTC_HOUR:   return {3'b000, b_hr};
      SEL_RTC_DAY_LO: return b_day[7:0];
      SEL_RTC_DAY_HI: return {b_carry, b_halt, 5'b00000, b_day[8]};
      default:        return OPEN_BUS;
    endcase
  endfunction

  task automatic clock_store(input logic [3:0] s, input logic [7:0] v);
    logic [7:0] m;
    case (s)
      SEL_RTC_SEC: begin
        m = v % 8'd60;
        sec = m[5:0];
      end
      SEL_RTC_MIN: begin
        m = v % 8'd60;
        mins = m[5:0];
      end
      SEL_RTC_HOUR: begin
        m = v % 8'd24;
        hrs = m[4:0];
      end
      SEL_RTC_DAY_LO: days[7:0] = v;
      SEL_RTC_DAY_HI: begin
        days[8] = v[0];
        halted = v[6];
        carry = v[7];
      end
      default: ;
    endcase
  endtask

  task automatic clock_tick();
    if (!halted) begin
      if (sec != 6'd59) sec = sec + 6'd1;
      else begin
        sec = 6'd0;
        if (mins != 6'd59) mins = mins + 6'd1;
        else begin
          mins = 6'd0;
          if (hrs != 5'd23) hrs = hrs + 5'd1;
          else begin
            hrs = 5'd0;
            if (days == 9'd511) begin
              days = 9'd0;
              carry = 1'b1;
            end else begin
              days = days + 9'd1;
            end
          end
        end
      end
    end
  endtask

  task automatic map_access(input req_e t, input logic [15:0] a, input logic [7:0] d,
                            output res_t r);
    logic       ext;
    logic       is_ram;
    logic       is_rtc;
    logic [6:0] rb;
    logic [1:0] mb;
    r = '{kind: KIND_NONE, mem_address: '0, read_data: '0, ram_write_data: '0};
    ext = (a >= 16'hA000) && (a <= 16'hBFFF) && ext_en;
    is_ram = (sel <= SEL_RAM_LAST) && (ram_count != 3'd0);
    is_rtc = (sel >= SEL_RTC_SEC) && (sel <= SEL_RTC_DAY_HI);
    rb = rom_sel_bank & 7'(count_mask(rom_count, ROM_BITS));
    mb = sel[1:0] & 2'(count_mask({5'b0, ram_count}, RAM_BITS));
    case (t)
      REQ_READ: begin
        if (a < 16'h4000) begin
          r.kind = KIND_ROM;
          r.mem_address = {5'b0, a};
        end else if (a < 16'h8000) begin
          r.kind = KIND_ROM;
          r.mem_address = {rb, a[13:0]};
        end else if (ext && is_ram) begin
          r.kind = KIND_RAM_RD;
          r.mem_address = {6'b0, mb, a[12:0]};
        end else begin
          r.kind = KIND_DATA;
          r.read_data = (ext && is_rtc) ? clock_byte(sel) : OPEN_BUS;
        end
      end
      REQ_WRITE: begin
        if (a <= 16'h1FFF) begin
          ext_en = (d[3:0] == ENABLE_KEY);
        end else if (a <= 16'h3FFF) begin
          rom_sel_bank = (d[6:0] == 7'd0) ? 7'd1 : d[6:0];
        end else if (a <= 16'h5FFF) begin
          sel = d[3:0];
        end else if (a <= 16'h7FFF) begin
          if (!arm && d[0]) begin
            snap_time = {2'b00, days, hrs, mins, sec};
            snap_flags = {carry, halted};
            has_latch = 1'b1;
          end
          arm = d[0];
        end else if (ext && is_ram) begin
          r.kind = KIND_RAM_WR;
          r.mem_address = {6'b0, mb, a[12:0]};
          r.ram_write_data = d;
        end else if (ext && is_rtc) begin
          clock_store(sel, d);
        end
      end
      REQ_TICK: clock_tick();
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h", field, $realtime, got, exp_val);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_count = ROM_COUNT_RST;
      ram_count = RAM_COUNT_RST;
      rom_sel_bank = 7'd1;
      sel = 4'd0;
      ext_en = 1'b0;
      arm = 1'b0;
      has_latch = 1'b0;
      sec = '0;
      mins = '0;
      hrs = '0;
      days = '0;
      halted = 1'b0;
      carry = 1'b0;
      snap_time = '0;
      snap_flags = '0;
      bus_results_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (bus_results_q.size() == 0) begin
          report_mismatch("unexpected result beat, kind", 32'(result_kind_i), 32'd0);
        end else begin
          want = bus_results_q.pop_front();
          if (result_kind_i != want.kind)
            report_mismatch("result_kind", 32'(result_kind_i), 32'(want.kind));
          if (mem_address_i != want.mem_address)
            report_mismatch("mem_address", 32'(mem_address_i), 32'(want.mem_address));
          if (read_data_i != want.read_data)
            report_mismatch("read_data", 32'(read_data_i), 32'(want.read_data));
          if (ram_write_data_i != want.ram_write_data)
            report_mismatch("ram_write_data", 32'(ram_write_data_i),
                            32'(want.ram_write_data));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ROM_BANK_COUNT: rom_count = cfg_data_i;
          CFG_RAM_BANK_COUNT: ram_count = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        map_access(req_e'(req_type_i), address_i, write_data_i, mapped);
        bus_results_q = {bus_results_q, mapped};
      end
      pending_o = bus_results_q.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// testbench top for the cartridge bank mapper: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_top;
  import cbmr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int PHASE_ITEMS    = 170;
  localparam int NUM_PHASES     = 6;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_RARE, STALL_HEAVY} stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [15:0] address_i;
  logic [7:0]  write_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  result_kind_o;
  logic [20:0] mem_address_o;
  logic [7:0]  read_data_o;
  logic [7:0]  ram_write_data_o;

  int          fail_count;
  int          pending;
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic        in_acc = 1'b0;
  logic        cfg_acc = 1'b0;
  logic        hold_off;

  logic [7:0]  rom_counts [NUM_PHASES] = '{8'd1, 8'd128, 8'd4, 8'd0, 8'd255, 8'd32};
  logic [7:0]  ram_counts [NUM_PHASES] = '{8'd1, 8'd4, 8'd2, 8'd7, 8'd3, 8'd0};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cartridge_bank_mapper_rtc_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .mem_address_o    (mem_address_o),
    .read_data_o      (read_data_o),
    .ram_write_data_o (ram_write_data_o)
  );

  cbmr_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .req_type_i       (req_type_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_i    (result_kind_o),
    .mem_address_i    (mem_address_o),
    .read_data_i      (read_data_o),
    .ram_write_data_i (ram_write_data_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always @(posedge clk_i) begin
    in_acc  <= in_valid_i && !in_stall_o;
    cfg_acc <= cfg_valid_i && cfg_ready_o;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // long sink hold-off so the block backs up and stalls its input
  initial begin
    hold_off = 1'b0;
    wait (items_sent >= 400);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    stall_mode_e mode;
    int          mode_left;
    logic        s;
    mode = STALL_NONE;
    mode_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        STALL_HALF:  s = ($urandom_range(0, 1) == 0);
        STALL_RARE:  s = ($urandom_range(0, 9) == 0);
        STALL_HEAVY: s = ($urandom_range(0, 4) != 0);
        default:     s = 1'b0;
      endcase
      out_stall_i = hold_off | s;
    end
  end

  task automatic write_cfg(input cfg_idx_e idx, input logic [7:0] v);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = v;
    do @(negedge clk_i); while (!cfg_acc);
    cfg_valid_i = 1'b0;
  endtask

  task automatic issue(input req_e t, input logic [15:0] a, input logic [7:0] d);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i = 1'b1;
    req_type_i = t;
    address_i = a;
    write_data_i = d;
    do @(negedge clk_i); while (!in_acc);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_rtc(input logic [3:0] s, input logic [7:0] v);
    logic [3:0] hi;
    hi = 4'($urandom_range(0, 15));
    issue(REQ_WRITE, 16'h4000 + 16'($urandom_range(0, 16'h1FFF)), {hi, s});
    issue(REQ_WRITE, 16'hA000 + 16'($urandom_range(0, 16'h1FFF)), v);
  endtask

  // drive the clock up to the last seconds of day 511, then tick and look at it
  task automatic near_midnight();
    logic c;
    int   n;
    c = 1'($urandom_range(0, 1));
    n = $urandom_range(1, 6);
    issue(REQ_WRITE, 16'h0000, 8'h0A);
    set_rtc(SEL_RTC_DAY_HI, {c, 7'b0000001});
    set_rtc(SEL_RTC_DAY_LO, 8'hFF);
    set_rtc(SEL_RTC_HOUR, 8'd23);
    set_rtc(SEL_RTC_MIN, 8'd59);
    set_rtc(SEL_RTC_SEC, 8'($urandom_range(55, 59)));
    repeat (n) issue(REQ_TICK, 16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)));
    issue(REQ_WRITE, 16'h6000, 8'h00);
    issue(REQ_WRITE, 16'h7FFF, 8'h01);
    issue(REQ_WRITE, 16'h4000, {4'h0, SEL_RTC_DAY_HI});
    issue(REQ_READ, 16'hA000 + 16'($urandom_range(0, 16'h1FFF)), 8'h00);
  endtask

  task automatic random_access();
    req_e       t;
    logic [15:0] a;
    logic [7:0]  d;
    int          pick;
    int          sub;
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 7);
    a = 16'($urandom_range(0, 16'hFFFF));
    d = 8'($urandom_range(0, 255));
    if (pick < 40) begin
      t = REQ_READ;
      case (sub)
        0: a = 16'($urandom_range(0, 16'h3FFF));
        1: a = 16'($urandom_range(16'h4000, 16'h7FFF));
        2, 3, 4: a = 16'($urandom_range(16'hA000, 16'hBFFF));
        5: a = 16'($urandom_range(16'h8000, 16'h9FFF));
        6: a = 16'($urandom_range(16'hC000, 16'hFFFF));
        default: ;
      endcase
    end else if (pick < 75) begin
      t = REQ_WRITE;
      case (sub)
        0: begin
          a = 16'($urandom_range(0, 16'h1FFF));
          if ($urandom_range(0, 2) != 0) d[3:0] = ENABLE_KEY;
        end
        1: a = 16'($urandom_range(16'h2000, 16'h3FFF));
        2: begin
          a = 16'($urandom_range(16'h4000, 16'h5FFF));
          if ($urandom_range(0, 2) == 0) d[3:0] = 4'($urandom_range(0, 3));
          else if ($urandom_range(0, 1) == 0) d[3:0] = 4'($urandom_range(8, 12));
        end
        3: a = 16'($urandom_range(16'h6000, 16'h7FFF));
        4, 5: a = 16'($urandom_range(16'hA000, 16'hBFFF));
        6: a = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(16'h8000, 16'h9FFF))
                                          : 16'($urandom_range(16'hC000, 16'hFFFF));
        default: ;
      endcase
    end else if (pick < 96) begin
      t = REQ_TICK;
    end else begin
      t = REQ_NONE;
    end
    issue(t, a, d);
  endtask

  task automatic run_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 3) near_midnight();
      else random_access();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ROM_BANK_COUNT;
    cfg_data_i = 8'h00;
    in_valid_i = 1'b0;
    req_type_i = REQ_READ;
    address_i = 16'h0000;
    write_data_i = 8'h00;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_cfg(CFG_ROM_BANK_COUNT, 8'd16);
    write_cfg(CFG_RAM_BANK_COUNT, 8'd4);

    issue(REQ_READ, 16'h0000, 8'h00);
    issue(REQ_WRITE, 16'h3FFF, 8'hFF);
    issue(REQ_READ, 16'h7FFF, 8'h00);
    issue(REQ_READ, 16'hA000, 8'h00);
    issue(REQ_WRITE, 16'h1FFF, 8'h1A);
    issue(REQ_WRITE, 16'h5FFF, 8'hF3);
    issue(REQ_WRITE, 16'hA000, 8'hA5);
    issue(REQ_READ, 16'hBFFF, 8'h00);
    issue(REQ_WRITE, 16'h2000, 8'h00);
    issue(REQ_READ, 16'h4000, 8'h00);
    issue(REQ_READ, 16'hFFFF, 8'hFF);
    set_rtc(SEL_RTC_DAY_HI, 8'h01);
    set_rtc(SEL_RTC_DAY_LO, 8'hFF);
    set_rtc(SEL_RTC_HOUR, 8'h17);
    set_rtc(SEL_RTC_MIN, 8'h3B);
    set_rtc(SEL_RTC_SEC, 8'h3B);
    issue(REQ_TICK, 16'h0000, 8'h00);
    issue(REQ_WRITE, 16'h7FFF, 8'h01);
    issue(REQ_WRITE, 16'h4000, {4'h0, SEL_RTC_DAY_HI});
    issue(REQ_READ, 16'hA000, 8'h00);
    issue(REQ_WRITE, 16'hC000, 8'h55);
    issue(REQ_NONE, 16'hFFFF, 8'hFF);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_cfg(CFG_ROM_BANK_COUNT, rom_counts[p]);
      write_cfg(CFG_RAM_BANK_COUNT, ram_counts[p]);
      run_random(PHASE_ITEMS);
      settle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
